### rtl/core/bmhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary max-heap priority queue package
// Shared widths, codes and bundles of the heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

	localparam int HEAP_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int KEY_W      = 32;
	localparam int POS_W      = 11;
	localparam int CNT_W      = 11;
	localparam int STATUS_W   = 3;
	localparam int OPCODE_W   = 2;
	localparam int TDATA_W    = 48;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_EXTRACT  = 2'd1,
		OP_INCREASE = 2'd2,
		OP_PEEK     = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_EMPTY   = 3'd1,
		STAT_FULL    = 3'd2,
		STAT_SMALLER = 3'd3,
		STAT_BADPOS  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ROOT_WAIT,
		S_INC_WAIT,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_RESP
	} state_t;

	typedef struct packed {
		opcode_t                  opcode;
		logic signed [KEY_W-1:0]  key;
		logic [POS_W-1:0]         position;
	} cmd_t;

	typedef struct packed {
		logic signed [KEY_W-1:0]  result_key;
		status_t                  status;
		logic [CNT_W-1:0]         occupancy;
	} resp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} ram_req_t;

endpackage

### rtl/core/bmhpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap storage RAM
// Synchronous RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bmhpq_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### rtl/core/bmhpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap operation sequencer
// Runs one operation at a time as a walk of read, compare and write steps
// over the heap RAM, and keeps the entry count.
// ----------------------------------------------------------------------------
module bmhpq_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  bmhpq_pkg::cmd_t                      in_cmd,
	output logic                                 resp_valid,
	input  logic                                 resp_ready,
	output bmhpq_pkg::resp_t                     resp,
	output bmhpq_pkg::ram_req_t                  ram_req,
	input  logic [bmhpq_pkg::KEY_W-1:0]          rdata_a,
	input  logic [bmhpq_pkg::KEY_W-1:0]          rdata_b
);

	localparam int CHILD_W = bmhpq_pkg::CNT_W + 1;

	bmhpq_pkg::state_t                    state_q;
	bmhpq_pkg::state_t                    state_d;
	bmhpq_pkg::opcode_t                   op_q;
	logic signed [bmhpq_pkg::KEY_W-1:0]   key_q;
	logic signed [bmhpq_pkg::KEY_W-1:0]   v_q;
	logic signed [bmhpq_pkg::KEY_W-1:0]   res_q;
	bmhpq_pkg::status_t                   st_q;
	logic [bmhpq_pkg::CNT_W-1:0]          pos_q;
	logic [bmhpq_pkg::CNT_W-1:0]          cnt_q;

	logic [bmhpq_pkg::CNT_W-1:0]          parent_pos;
	logic [CHILD_W-1:0]                   child_pos;
	logic                                 child_in;
	logic                                 right_in;
	logic                                 take_right;
	logic [bmhpq_pkg::KEY_W-1:0]          big_key;
	logic                                 up_move;
	logic                                 dn_move;
	logic                                 inc_smaller;
	logic                                 is_full;
	logic                                 is_empty;
	logic                                 bad_pos;

	function automatic logic [bmhpq_pkg::ADDR_W-1:0] pos2addr(
		input logic [CHILD_W-1:0] p
	);
		logic [CHILD_W-1:0] a;
		a = p - CHILD_W'(1);
		return a[bmhpq_pkg::ADDR_W-1:0];
	endfunction

	assign parent_pos  = pos_q >> 1;
	assign child_pos   = {pos_q, 1'b0};
	assign child_in    = child_pos <= {1'b0, cnt_q};
	assign right_in    = child_pos < {1'b0, cnt_q};
	assign take_right  = right_in && ($signed(rdata_a) < $signed(rdata_b));
	assign big_key     = take_right ? rdata_b : rdata_a;
	assign up_move     = $signed(rdata_a) < v_q;
	assign dn_move     = v_q < $signed(big_key);
	assign inc_smaller = key_q < $signed(rdata_a);
	assign is_full     = cnt_q == bmhpq_pkg::CNT_W'(bmhpq_pkg::HEAP_DEPTH);
	assign is_empty    = cnt_q == '0;
	assign bad_pos     = (pos_q == '0) || (pos_q > cnt_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bmhpq_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = bmhpq_pkg::S_DISPATCH;
				end
			end
			bmhpq_pkg::S_DISPATCH: begin
				case (op_q)
					bmhpq_pkg::OP_INSERT:
						state_d = is_full ? bmhpq_pkg::S_RESP : bmhpq_pkg::S_UP_RD;
					bmhpq_pkg::OP_INCREASE:
						state_d = bad_pos ? bmhpq_pkg::S_RESP : bmhpq_pkg::S_INC_WAIT;
					default:
						state_d = is_empty ? bmhpq_pkg::S_RESP : bmhpq_pkg::S_ROOT_WAIT;
				endcase
			end
			bmhpq_pkg::S_ROOT_WAIT: begin
				if (op_q == bmhpq_pkg::OP_EXTRACT && cnt_q != bmhpq_pkg::CNT_W'(1)) begin
					state_d = bmhpq_pkg::S_DN_RD;
				end else begin
					state_d = bmhpq_pkg::S_RESP;
				end
			end
			bmhpq_pkg::S_INC_WAIT: begin
				state_d = inc_smaller ? bmhpq_pkg::S_RESP : bmhpq_pkg::S_UP_RD;
			end
			bmhpq_pkg::S_UP_RD: begin
				if (pos_q == bmhpq_pkg::CNT_W'(1)) begin
					state_d = bmhpq_pkg::S_RESP;
				end else begin
					state_d = bmhpq_pkg::S_UP_CMP;
				end
			end
			bmhpq_pkg::S_UP_CMP: begin
				state_d = up_move ? bmhpq_pkg::S_UP_RD : bmhpq_pkg::S_RESP;
			end
			bmhpq_pkg::S_DN_RD: begin
				state_d = child_in ? bmhpq_pkg::S_DN_CMP : bmhpq_pkg::S_RESP;
			end
			bmhpq_pkg::S_DN_CMP: begin
				state_d = dn_move ? bmhpq_pkg::S_DN_RD : bmhpq_pkg::S_RESP;
			end
			bmhpq_pkg::S_RESP: begin
				if (resp_ready) begin
					state_d = bmhpq_pkg::S_IDLE;
				end
			end
			default: state_d = bmhpq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ram_req         = '0;
		ram_req.raddr_a = pos2addr({1'b0, pos_q});
		ram_req.raddr_b = pos2addr({1'b0, cnt_q});
		ram_req.waddr   = pos2addr({1'b0, pos_q});
		ram_req.wdata   = v_q;
		in_ready        = 1'b0;
		resp_valid      = 1'b0;
		case (state_q)
			bmhpq_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			bmhpq_pkg::S_DISPATCH: begin
				if (op_q == bmhpq_pkg::OP_EXTRACT || op_q == bmhpq_pkg::OP_PEEK) begin
					ram_req.raddr_a = '0;
				end
			end
			bmhpq_pkg::S_UP_RD: begin
				ram_req.raddr_a = pos2addr({1'b0, parent_pos});
				ram_req.we      = pos_q == bmhpq_pkg::CNT_W'(1);
			end
			bmhpq_pkg::S_UP_CMP: begin
				ram_req.we = 1'b1;
				if (up_move) begin
					ram_req.wdata = rdata_a;
				end
			end
			bmhpq_pkg::S_DN_RD: begin
				ram_req.raddr_a = pos2addr(child_pos);
				ram_req.raddr_b = child_pos[bmhpq_pkg::ADDR_W-1:0];
				ram_req.we      = !child_in;
			end
			bmhpq_pkg::S_DN_CMP: begin
				ram_req.we = 1'b1;
				if (dn_move) begin
					ram_req.wdata = big_key;
				end
			end
			bmhpq_pkg::S_RESP: begin
				resp_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhpq_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bmhpq_pkg::S_DISPATCH && op_q == bmhpq_pkg::OP_INSERT
			    && !is_full) begin
				cnt_q <= cnt_q + bmhpq_pkg::CNT_W'(1);
			end
			if (state_q == bmhpq_pkg::S_ROOT_WAIT && op_q == bmhpq_pkg::OP_EXTRACT) begin
				cnt_q <= cnt_q - bmhpq_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bmhpq_pkg::S_IDLE: begin
				op_q  <= in_cmd.opcode;
				key_q <= in_cmd.key;
				pos_q <= in_cmd.position;
				res_q <= '0;
				st_q  <= bmhpq_pkg::STAT_OK;
			end
			bmhpq_pkg::S_DISPATCH: begin
				case (op_q)
					bmhpq_pkg::OP_INSERT: begin
						v_q   <= key_q;
						pos_q <= cnt_q + bmhpq_pkg::CNT_W'(1);
						if (is_full) begin
							st_q <= bmhpq_pkg::STAT_FULL;
						end
					end
					bmhpq_pkg::OP_INCREASE: begin
						if (bad_pos) begin
							st_q <= bmhpq_pkg::STAT_BADPOS;
						end
					end
					default: begin
						if (is_empty) begin
							st_q <= bmhpq_pkg::STAT_EMPTY;
						end
					end
				endcase
			end
			bmhpq_pkg::S_ROOT_WAIT: begin
				res_q <= $signed(rdata_a);
				v_q   <= $signed(rdata_b);
				pos_q <= bmhpq_pkg::CNT_W'(1);
			end
			bmhpq_pkg::S_INC_WAIT: begin
				v_q <= key_q;
				if (inc_smaller) begin
					st_q <= bmhpq_pkg::STAT_SMALLER;
				end
			end
			bmhpq_pkg::S_UP_CMP: begin
				if (up_move) begin
					pos_q <= parent_pos;
				end
			end
			bmhpq_pkg::S_DN_CMP: begin
				if (dn_move) begin
					pos_q <= take_right ? child_pos[bmhpq_pkg::CNT_W-1:0] + bmhpq_pkg::CNT_W'(1)
					                    : child_pos[bmhpq_pkg::CNT_W-1:0];
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign resp.result_key = res_q;
	assign resp.status     = st_q;
	assign resp.occupancy  = cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bmhpq_pkg::CNT_W'(bmhpq_pkg::HEAP_DEPTH))
		else $error("entry count exceeds heap depth");

	a_up_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bmhpq_pkg::S_UP_CMP |-> pos_q > bmhpq_pkg::CNT_W'(1))
		else $error("sift-up compared at the root");

	a_dn_child_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bmhpq_pkg::S_DN_CMP |-> child_pos <= {1'b0, cnt_q})
		else $error("sift-down compared a child beyond the last entry");

	a_extract_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmhpq_pkg::S_ROOT_WAIT && op_q == bmhpq_pkg::OP_EXTRACT)
		|=> cnt_q == $past(cnt_q) - bmhpq_pkg::CNT_W'(1))
		else $error("extract did not remove one entry");

endmodule

### rtl/core/binary_max_heap_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary max-heap priority queue
// Each transaction on the slave stream is one heap operation, selected by
// tuser: insert, extract maximum, increase key at a position, or peek.
// Each operation gives exactly one result transaction on the master stream,
// carrying the maximum key (extract and peek), a status code and the number
// of entries after the operation.
// Keys live in a 1024-entry synchronous RAM with two read ports. Each level
// of sift-up is a parent read, then a compare and write; each level of
// sift-down is a read of both children together, then a compare and write.
// One operation is worked at a time, and the next one is accepted only after
// the previous result has moved into the output register.
// The result sits in an output register, so the next operation is accepted
// while the previous result waits for the receiver; a stalled receiver holds
// back only the following result.
// Reset empties the heap at once; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// key [31:0], position [42:32], zero fill [47:43]
	input  logic [bmhpq_pkg::TDATA_W-1:0]      s_axis_tdata,
	// opcode [1:0]
	input  logic [bmhpq_pkg::OPCODE_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// result_key [31:0], occupancy [42:32], zero fill [47:43]
	output logic [bmhpq_pkg::TDATA_W-1:0]      m_axis_tdata,
	// status [2:0]
	output logic [bmhpq_pkg::STATUS_W-1:0]     m_axis_tuser
);

	localparam int FILL_W = bmhpq_pkg::TDATA_W - bmhpq_pkg::KEY_W - bmhpq_pkg::CNT_W;

	bmhpq_pkg::cmd_t                  cmd;
	bmhpq_pkg::resp_t                 resp;
	bmhpq_pkg::resp_t                 out_q;
	bmhpq_pkg::ram_req_t              ram_req;
	logic                             resp_valid;
	logic                             resp_ready;
	logic                             out_valid_q;
	logic [bmhpq_pkg::KEY_W-1:0]      rdata_a;
	logic [bmhpq_pkg::KEY_W-1:0]      rdata_b;

	assign cmd.opcode   = bmhpq_pkg::opcode_t'(s_axis_tuser);
	assign cmd.key      = s_axis_tdata[bmhpq_pkg::KEY_W-1:0];
	assign cmd.position = s_axis_tdata[bmhpq_pkg::KEY_W +: bmhpq_pkg::POS_W];

	bmhpq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_cmd     (cmd),
		.resp_valid (resp_valid),
		.resp_ready (resp_ready),
		.resp       (resp),
		.ram_req    (ram_req),
		.rdata_a    (rdata_a),
		.rdata_b    (rdata_b)
	);

	bmhpq_ram #(
		.DATA_W (bmhpq_pkg::KEY_W),
		.ADDR_W (bmhpq_pkg::ADDR_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_req.we),
		.waddr   (ram_req.waddr),
		.wdata   (ram_req.wdata),
		.raddr_a (ram_req.raddr_a),
		.raddr_b (ram_req.raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign resp_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_valid && resp_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_valid && resp_ready) begin
			out_q <= resp;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{FILL_W{1'b0}}, out_q.occupancy, out_q.result_key};
	assign m_axis_tuser  = out_q.status;

endmodule
